>>> rtl/core/fltcm_pkg.sv
// Shared widths, constants and types of the filtered temperature color map.
`timescale 1ns / 1ps

package fltcm_pkg;

  localparam int TEMP_W   = 13;
  localparam int DIV_W    = 10;
  localparam int LEVEL_W  = 10;
  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 7;
  localparam int NUM_W    = 25;
  localparam int MAG_W    = 24;
  localparam int CNT_W    = $clog2(MAG_W);

  localparam int MODE_COUNT = 3;

  localparam logic [MODE_W-1:0] MD_NORMAL   = 2'd0;
  localparam logic [MODE_W-1:0] MD_EXTENDED = 2'd1;
  localparam logic [MODE_W-1:0] MD_SWEEP    = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_NORMAL = 7'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_SWEEP  = 7'd1;

  localparam logic [DIV_W-1:0]   ALPHA_RESET = 10'd40;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 10'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 10'd0;

  localparam int TEMP_POS_LIMIT = 4095;
  localparam int TEMP_NEG_LIMIT = 4096;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 13'sh1000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sh0fff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SAT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/fltcm_in_if.sv
// Input channel: temperature sample and button level.
`timescale 1ns / 1ps

interface fltcm_in_if import fltcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_sample;
  logic                     button_level;

  modport source (output valid, output temperature_sample, output button_level, input ready);
  modport sink   (input valid, input temperature_sample, input button_level, output ready);
endinterface

>>> rtl/core/fltcm_out_if.sv
// Output channel: color levels, mode, tick period and smoothed temperature.
`timescale 1ns / 1ps

interface fltcm_out_if import fltcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [LEVEL_W-1:0]       red_level;
  logic [LEVEL_W-1:0]       green_level;
  logic [LEVEL_W-1:0]       blue_level;
  logic                     color_valid;
  logic [MODE_W-1:0]        mode_now;
  logic [PERIOD_W-1:0]      tick_period_ms;
  logic signed [TEMP_W-1:0] smoothed_temperature;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output color_valid, output mode_now, output tick_period_ms,
                  output smoothed_temperature, input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  input color_valid, input mode_now, input tick_period_ms,
                  input smoothed_temperature, output ready);
endinterface

>>> rtl/core/fltcm_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fltcm_divider import fltcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [MAG_W-1:0] quotient_o
);

  logic [DIV_W-1:0] divisor_q;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[MAG_W-1]};
    fits      = rem_shift >= {1'b0, divisor_q};
    rem_sub   = rem_shift - {1'b0, divisor_q};
    rem_d     = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    quo_d     = {quo_q[MAG_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> rtl/core/fltcm_ramp.sv
// Eight-segment piecewise-linear color ramp over the smoothed temperature.
`timescale 1ns / 1ps

module fltcm_ramp import fltcm_pkg::*; (
  input  logic signed [TEMP_W-1:0] temp_i,
  output logic [LEVEL_W-1:0]       red_o,
  output logic [LEVEL_W-1:0]       green_o,
  output logic [LEVEL_W-1:0]       blue_o
);

  localparam logic signed [TEMP_W-1:0] T_N400 = -13'sd400;
  localparam logic signed [TEMP_W-1:0] T_N200 = -13'sd200;
  localparam logic signed [TEMP_W-1:0] T_0    = 13'sd0;
  localparam logic signed [TEMP_W-1:0] T_200  = 13'sd200;
  localparam logic signed [TEMP_W-1:0] T_400  = 13'sd400;
  localparam logic signed [TEMP_W-1:0] T_600  = 13'sd600;
  localparam logic signed [TEMP_W-1:0] T_800  = 13'sd800;

  function automatic logic [LEVEL_W-1:0] times5(input logic signed [TEMP_W-1:0] d);
    logic [7:0] x;
    x = d[7:0];
    return {x, 2'b00} + {2'b00, x};
  endfunction

  logic signed [TEMP_W-1:0] d_n200_t, d_0_t, d_200_t, d_t_200, d_400_t, d_t_400, d_t_600;

  always_comb begin
    d_n200_t = T_N200 - temp_i;
    d_0_t    = T_0 - temp_i;
    d_200_t  = T_200 - temp_i;
    d_t_200  = temp_i - T_200;
    d_400_t  = T_400 - temp_i;
    d_t_400  = temp_i - T_400;
    d_t_600  = temp_i - T_600;

    priority if (temp_i < T_N400) begin
      red_o = LEVEL_MAX;          green_o = LEVEL_MAX;          blue_o = LEVEL_MAX;
    end else if (temp_i < T_N200) begin
      red_o = LEVEL_MAX;          green_o = times5(d_n200_t);   blue_o = LEVEL_MAX;
    end else if (temp_i < T_0) begin
      red_o = times5(d_0_t);      green_o = LEVEL_ZERO;         blue_o = LEVEL_MAX;
    end else if (temp_i < T_200) begin
      red_o = LEVEL_ZERO;         green_o = times5(temp_i);     blue_o = times5(d_200_t);
    end else if (temp_i < T_400) begin
      red_o = times5(d_t_200);    green_o = times5(d_400_t);    blue_o = LEVEL_ZERO;
    end else if (temp_i < T_600) begin
      red_o = LEVEL_MAX;          green_o = LEVEL_ZERO;         blue_o = times5(d_t_400);
    end else if (temp_i < T_800) begin
      red_o = LEVEL_MAX;          green_o = times5(d_t_600);    blue_o = LEVEL_MAX;
    end else begin
      red_o = LEVEL_MAX;          green_o = LEVEL_MAX;          blue_o = LEVEL_MAX;
    end
  end

endmodule

>>> rtl/core/filtered_temperature_color_map.sv
// Top level: exponential temperature filter, mode sequencer and color ramp.
// Sequence: idle takes the input beat, then start, divide, saturate and finish load the result beat.
// Items are handled one at a time, each through the 24-step serial divider.
// Ready stays low from the input beat until the result is loaded.
// The result register lets the next input beat in while a result waits.
// Reset: filter 0, mode normal, button released, divisor 40, no result pending.
`timescale 1ns / 1ps

module filtered_temperature_color_map import fltcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DIV_W-1:0] cfg_wdata_i,
  fltcm_in_if.sink         in_chan,
  fltcm_out_if.source      out_chan
);

  state_e state_q, state_d;

  logic [DIV_W-1:0]         alpha_q;
  logic [DIV_W-1:0]         divisor_q;
  logic signed [NUM_W-1:0]  num_q;
  logic                     press_q;
  logic signed [TEMP_W-1:0] filtered_q, filtered_d;
  logic                     btn_was_q;
  logic [MODE_W-1:0]        mode_q, mode_d, mode_cur;

  logic                     res_valid_q;
  logic [LEVEL_W-1:0]       red_q, green_q, blue_q;
  logic                     color_valid_q;
  logic [MODE_W-1:0]        mode_out_q;
  logic [PERIOD_W-1:0]      period_q;
  logic signed [TEMP_W-1:0] smooth_q;

  logic                     accept;
  logic                     div_start;
  logic                     load_res;
  logic                     filt_we;
  logic [DIV_W-1:0]         alpha_eff;
  logic signed [NUM_W-1:0]  op_a, op_b, smp_ext, num_d, num_neg;
  logic [MAG_W-1:0]         dividend;
  logic [MAG_W-1:0]         quotient;
  div_stat_t                div_stat;
  logic [LEVEL_W-1:0]       ramp_r, ramp_g, ramp_b;
  logic                     sweep;

  fltcm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  fltcm_ramp u_ramp (
    .temp_i  (filtered_q),
    .red_o   (ramp_r),
    .green_o (ramp_g),
    .blue_o  (ramp_b)
  );

  always_comb begin
    alpha_eff = (alpha_q == '0) ? DIV_W'(1) : alpha_q;
    op_a      = $signed({{(NUM_W-DIV_W){1'b0}}, alpha_eff - DIV_W'(1)});
    op_b      = {{(NUM_W-TEMP_W){filtered_q[TEMP_W-1]}}, filtered_q};
    smp_ext   = {{(NUM_W-TEMP_W){in_chan.temperature_sample[TEMP_W-1]}},
                 in_chan.temperature_sample};
    num_d     = op_a * op_b + smp_ext;
    num_neg   = -num_q;
    dividend  = num_q[NUM_W-1] ? num_neg[MAG_W-1:0] : num_q[MAG_W-1:0];
  end

  always_comb begin
    if (num_q[NUM_W-1]) begin
      if (quotient > MAG_W'(TEMP_NEG_LIMIT)) begin
        filtered_d = TEMP_MIN;
      end else begin
        filtered_d = -$signed(quotient[TEMP_W-1:0]);
      end
    end else begin
      if (quotient > MAG_W'(TEMP_POS_LIMIT)) begin
        filtered_d = TEMP_MAX;
      end else begin
        filtered_d = $signed(quotient[TEMP_W-1:0]);
      end
    end
  end

  always_comb begin
    mode_cur = (mode_q >= MODE_W'(MODE_COUNT)) ? MD_NORMAL : mode_q;
    mode_d   = mode_cur;
    if (press_q && !btn_was_q) begin
      mode_d = (mode_cur + MODE_W'(1) >= MODE_W'(MODE_COUNT)) ? MD_NORMAL
                                                              : mode_cur + MODE_W'(1);
    end
    sweep = (mode_d == MD_SWEEP);
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load_res  = 1'b0;
    filt_we   = 1'b0;
    in_chan.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        filt_we = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid_q || out_chan.ready) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= ALPHA_RESET;
      filtered_q  <= '0;
      btn_was_q   <= 1'b0;
      mode_q      <= MD_NORMAL;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (filt_we) begin
        filtered_q <= filtered_d;
      end
      if (load_res) begin
        btn_was_q   <= press_q;
        mode_q      <= mode_d;
        res_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q     <= num_d;
      press_q   <= in_chan.button_level;
      divisor_q <= alpha_eff;
    end
    if (load_res) begin
      red_q         <= sweep ? LEVEL_ZERO : ramp_r;
      green_q       <= sweep ? LEVEL_ZERO : ramp_g;
      blue_q        <= sweep ? LEVEL_ZERO : ramp_b;
      color_valid_q <= !sweep;
      mode_out_q    <= mode_d;
      period_q      <= sweep ? PERIOD_SWEEP : PERIOD_NORMAL;
      smooth_q      <= filtered_q;
    end
  end

  assign out_chan.valid                = res_valid_q;
  assign out_chan.red_level            = red_q;
  assign out_chan.green_level          = green_q;
  assign out_chan.blue_level           = blue_q;
  assign out_chan.color_valid          = color_valid_q;
  assign out_chan.mode_now             = mode_out_q;
  assign out_chan.tick_period_ms       = period_q;
  assign out_chan.smoothed_temperature = smooth_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_beat_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_chan.ready)
    else $error("input beat taken while an item is in progress");

  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> red_q <= LEVEL_MAX && green_q <= LEVEL_MAX && blue_q <= LEVEL_MAX)
    else $error("color level above full scale");

  a_invalid_means_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !color_valid_q |-> mode_out_q == MD_SWEEP && period_q == PERIOD_SWEEP)
    else $error("color flagged invalid outside sweep mode");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the filtered temperature color map.
`timescale 1ns / 1ps

module testbench;
  import fltcm_pkg::*;

  localparam int LIMIT_CYCLES  = 900000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 181;

  typedef struct packed {
    logic [LEVEL_W-1:0]       red;
    logic [LEVEL_W-1:0]       green;
    logic [LEVEL_W-1:0]       blue;
    logic                     color_ok;
    logic [MODE_W-1:0]        mode;
    logic [PERIOD_W-1:0]      period;
    logic signed [TEMP_W-1:0] smoothed;
  } color_beat_t;

  typedef struct {
    bit          is_cfg;
    int          value;
    bit          btn;
    bit          typed;
    color_beat_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [DIV_W-1:0] cfg_wdata;

  fltcm_in_if  in_chan ();
  fltcm_out_if out_chan ();

  filtered_temperature_color_map DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  always #6 clk = ~clk;

  logic [DIV_W-1:0]  divisor_q = ALPHA_RESET;
  int                smooth_q  = 0;
  logic [MODE_W-1:0] mode_q    = MD_NORMAL;
  logic              pressed_q = 1'b0;

  color_beat_t color_expect_q[$];
  color_beat_t seen_beat;
  color_beat_t want_beat;
  stim_row_t   directed_rows[$];

  int  fail_count    = 0;
  int  cycle_count   = 0;
  int  hold_left     = 0;
  int  stall_left    = 0;
  bit  long_hold_req = 1'b0;
  bit  steady        = 1'b0;

  function automatic color_beat_t predict_color(logic signed [TEMP_W-1:0] temp, logic btn);
    color_beat_t res;
    int a, t, rr, gg, bb;
    a = (divisor_q == '0) ? 1 : int'(divisor_q);
    t = ((a - 1) * smooth_q + int'(temp)) / a;
    if (t > TEMP_POS_LIMIT) t = TEMP_POS_LIMIT;
    if (t < -TEMP_NEG_LIMIT) t = -TEMP_NEG_LIMIT;
    smooth_q = t;
    if (mode_q >= MODE_COUNT) mode_q = MD_NORMAL;
    if (btn && !pressed_q) begin
      mode_q = mode_q + 2'd1;
      if (mode_q >= MODE_COUNT) mode_q = MD_NORMAL;
    end
    pressed_q = btn;
    res = '0;
    res.mode = mode_q;
    res.smoothed = t[TEMP_W-1:0];
    if (mode_q == MD_SWEEP) begin
      res.period = PERIOD_SWEEP;
    end else begin
      res.period = PERIOD_NORMAL;
      res.color_ok = 1'b1;
      if (t < -400) begin
        rr = 1000; gg = 1000; bb = 1000;
      end else if (t < -200) begin
        rr = 1000; gg = 5 * (-t - 200); bb = 1000;
      end else if (t < 0) begin
        rr = 5 * (-t); gg = 0; bb = 1000;
      end else if (t < 200) begin
        rr = 0; gg = 5 * t; bb = 5 * (200 - t);
      end else if (t < 400) begin
        rr = 5 * (t - 200); gg = 5 * (400 - t); bb = 0;
      end else if (t < 600) begin
        rr = 1000; gg = 0; bb = 5 * (t - 400);
      end else if (t < 800) begin
        rr = 1000; gg = 5 * (t - 600); bb = 1000;
      end else begin
        rr = 1000; gg = 1000; bb = 1000;
      end
      res.red   = rr[LEVEL_W-1:0];
      res.green = gg[LEVEL_W-1:0];
      res.blue  = bb[LEVEL_W-1:0];
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  function automatic stim_row_t row_cfg(int v);
    stim_row_t row;
    row = '{is_cfg: 1'b1, value: v, btn: 1'b0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t row_pred(int t, bit b);
    stim_row_t row;
    row = '{is_cfg: 1'b0, value: t, btn: b, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t row_chk(int t, bit b, int r, int g, int bl, bit cv,
                                        logic [MODE_W-1:0] m);
    stim_row_t row;
    row = row_pred(t, b);
    row.typed          = 1'b1;
    row.want.red       = r[LEVEL_W-1:0];
    row.want.green     = g[LEVEL_W-1:0];
    row.want.blue      = bl[LEVEL_W-1:0];
    row.want.color_ok  = cv;
    row.want.mode      = m;
    row.want.period    = (m == MD_SWEEP) ? PERIOD_SWEEP : PERIOD_NORMAL;
    row.want.smoothed  = t[TEMP_W-1:0];
    return row;
  endfunction

  task automatic send_beat(logic signed [TEMP_W-1:0] temp, logic btn, bit typed,
                           color_beat_t want);
    color_beat_t predicted;
    int gap;
    in_chan.valid              <= 1'b1;
    in_chan.temperature_sample <= temp;
    in_chan.button_level       <= btn;
    do @(posedge clk); while (!in_chan.ready);
    predicted = predict_color(temp, btn);
    color_expect_q.push_back(typed ? want : predicted);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (color_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[DIV_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    divisor_q = v[DIV_W-1:0];
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      seen_beat.red      = out_chan.red_level;
      seen_beat.green    = out_chan.green_level;
      seen_beat.blue     = out_chan.blue_level;
      seen_beat.color_ok = out_chan.color_valid;
      seen_beat.mode     = out_chan.mode_now;
      seen_beat.period   = out_chan.tick_period_ms;
      seen_beat.smoothed = out_chan.smoothed_temperature;
      if (color_expect_q.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual smoothed %0d",
                 $time, int'(seen_beat.smoothed));
        fail_count++;
      end else begin
        want_beat = color_expect_q.pop_front();
        compare_field("red_level", int'(want_beat.red), int'(seen_beat.red));
        compare_field("green_level", int'(want_beat.green), int'(seen_beat.green));
        compare_field("blue_level", int'(want_beat.blue), int'(seen_beat.blue));
        compare_field("color_valid", int'(want_beat.color_ok), int'(seen_beat.color_ok));
        compare_field("mode_now", int'(want_beat.mode), int'(seen_beat.mode));
        compare_field("tick_period_ms", int'(want_beat.period), int'(seen_beat.period));
        compare_field("smoothed_temperature", int'(want_beat.smoothed),
                      int'(seen_beat.smoothed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, color_expect_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_chan.ready <= 1'b0;
      end else if (steady) begin
        out_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_chan.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    logic signed [TEMP_W-1:0] temp;
    logic btn;
    int sel, div;
    int edges[16];
    int phase_div[PHASES];
    edges = '{-4096, -401, -400, -201, -200, -1, 0, 199, 200, 399, 400, 599, 600, 799,
              800, 4095};
    phase_div = '{1023, 2, 40, 0, 1, 0, 0, 700};

    in_chan.valid              <= 1'b0;
    in_chan.temperature_sample <= '0;
    in_chan.button_level       <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_wdata                  <= '0;
    rst_n                      <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows.push_back(row_chk(0, 0, 0, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_cfg(1));
    directed_rows.push_back(row_chk(4095, 0, 1000, 1000, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-4096, 0, 1000, 1000, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-401, 0, 1000, 1000, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-400, 0, 1000, 1000, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-300, 0, 1000, 500, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-200, 0, 1000, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(-100, 0, 500, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(0, 0, 0, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(100, 0, 0, 500, 500, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(200, 0, 0, 1000, 0, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(400, 0, 1000, 0, 0, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(600, 0, 1000, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(700, 0, 1000, 500, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(799, 0, 1000, 995, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(800, 0, 1000, 1000, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_chk(0, 1, 0, 0, 1000, 1, MD_EXTENDED));
    directed_rows.push_back(row_chk(100, 1, 0, 500, 500, 1, MD_EXTENDED));
    directed_rows.push_back(row_chk(0, 0, 0, 0, 1000, 1, MD_EXTENDED));
    directed_rows.push_back(row_chk(4095, 1, 0, 0, 0, 0, MD_SWEEP));
    directed_rows.push_back(row_chk(-4096, 0, 0, 0, 0, 0, MD_SWEEP));
    directed_rows.push_back(row_chk(0, 1, 0, 0, 1000, 1, MD_NORMAL));
    directed_rows.push_back(row_cfg(0));
    directed_rows.push_back(row_pred(-1234, 0));
    directed_rows.push_back(row_pred(2047, 0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_divisor(directed_rows[i].value);
      end else begin
        temp = TEMP_W'(directed_rows[i].value);
        send_beat(temp, directed_rows[i].btn, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    btn = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      div = (phase == 3 || phase == 6) ? int'($urandom_range(3, 1022)) : phase_div[phase];
      write_divisor(div);
      steady = (phase == 1 || phase == 6);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 3 && n == 40) long_hold_req = 1'b1;
        if (phase == 5 && n == 90) drain();
        sel = $urandom_range(0, 9);
        if (sel < 4) temp = TEMP_W'(int'($urandom_range(0, 1400)) - 500);
        else if (sel < 8) temp = TEMP_W'($urandom_range(0, 8191));
        else temp = TEMP_W'(edges[$urandom_range(0, 15)]);
        if ($urandom_range(0, 9) < 3) btn = ~btn;
        send_beat(temp, btn, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
